// ----- design/uwt_pkg.sv -----
package uwt_pkg;

    localparam int LEN_W   = 14;   // width of the reported token length
    localparam int TAIL_W  = 3;    // continuation bytes still owed, 0..5
    localparam int SLOTS   = 3;    // most results one text byte can cause
    localparam int SLOT_W  = 2;
    localparam int QDEPTH  = 4;    // entries between front and back
    localparam int QPTR_W  = 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // register index, taken from paddr[2]
    localparam logic REG_SKIP_LB = 1'b0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // lead byte prefixes for 3, 4, 5 and 6 byte characters
    localparam logic [3:0] LEAD3 = 4'hE;
    localparam logic [4:0] LEAD4 = 5'h1E;
    localparam logic [5:0] LEAD5 = 6'h3E;
    localparam logic [6:0] LEAD6 = 7'h7E;

    typedef struct packed {
        logic [7:0]       data;
        logic             first;
        logic             is_end;
        logic             ascii;
        logic [LEN_W-1:0] len;
    } t_result;

    typedef struct packed {
        logic [SLOT_W-1:0]         count;
        t_result [SLOTS-1:0]       res;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_alnum(input logic [7:0] b);
        logic lower, upper, digit;
        lower = (b >= 8'h61) && (b <= 8'h7A);
        upper = (b >= 8'h41) && (b <= 8'h5A);
        digit = (b >= 8'h30) && (b <= 8'h39);
        return lower || upper || digit;
    endfunction

    function automatic logic [TAIL_W-1:0] lead_tail(input logic [7:0] b);
        logic [TAIL_W-1:0] t;
        if (b[7:4] == LEAD3) begin
            t = TAIL_W'(2);
        end else if (b[7:3] == LEAD4) begin
            t = TAIL_W'(3);
        end else if (b[7:2] == LEAD5) begin
            t = TAIL_W'(4);
        end else if (b[7:1] == LEAD6) begin
            t = TAIL_W'(5);
        end else begin
            t = '0;
        end
        return t;
    endfunction

endpackage

// ----- design/uwt_front.sv -----
module uwt_front #(
    parameter int MAX_TOKEN_LEN = 10240
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_text_byte,
    input  logic                i_skip_lb,
    input  uwt_pkg::t_qstat     i_qstat,
    output logic                o_push,
    output uwt_pkg::t_entry     o_entry
);

    localparam int CLOG = $clog2(MAX_TOKEN_LEN + 2);
    localparam int CW   = (CLOG > uwt_pkg::LEN_W) ? CLOG : uwt_pkg::LEN_W;
    localparam logic [CW-1:0] LIMIT = CW'(MAX_TOKEN_LEN + 1);

    logic                        r_esc, n_esc;
    logic                        r_open, n_open;
    logic [CW-1:0]               r_len, n_len;
    logic [uwt_pkg::TAIL_W-1:0]  r_tail, n_tail;
    logic                        r_seen, n_seen;
    logic                        r_fbh, n_fbh;

    logic                        accept;
    logic [7:0]                  b;
    logic                        aln, blank, pre, o1, skip, tail_done, post;
    logic [uwt_pkg::TAIL_W-1:0]  t1;
    logic [CW-1:0]               len_after;
    logic                        fbh_after;
    logic [uwt_pkg::SLOT_W-1:0]  k;
    uwt_pkg::t_result [uwt_pkg::SLOTS-1:0] res;

    assign b       = i_text_byte;
    assign o_ready = !i_qstat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        aln   = uwt_pkg::is_alnum(b);
        blank = (b == uwt_pkg::CH_SPACE) || (b == uwt_pkg::CH_TAB) ||
                (i_skip_lb && ((b == uwt_pkg::CH_CR) || (b == uwt_pkg::CH_LF)));
        // close the open token first when this byte cannot join it
        pre = r_open && (r_tail == '0) &&
              ((!b[7] && !aln) || (b[7] && r_seen));
        o1        = r_open && !pre;
        t1        = pre ? '0 : r_tail;
        skip      = !b[7] && !aln && !o1 && blank;
        len_after = (o1 ? r_len : '0) + 1'b1;
        fbh_after = o1 ? r_fbh : b[7];
        tail_done = o1 && (t1 == uwt_pkg::TAIL_W'(1));
        post      = tail_done || (!b[7] && !aln && !(o1 && t1 != '0)) ||
                    (len_after == LIMIT);
    end

    always_comb begin
        n_esc  = r_esc;
        n_open = r_open;
        n_len  = r_len;
        n_tail = r_tail;
        n_seen = r_seen;
        n_fbh  = r_fbh;
        k      = '0;
        res    = '0;
        if (!r_esc && (b == uwt_pkg::CH_BSLASH)) begin
            n_esc = 1'b1;
        end else if (b == uwt_pkg::CH_NUL) begin
            n_esc = 1'b0;
            res[k] = '{data: 8'h00, first: 1'b0, is_end: 1'b1, ascii: !r_fbh,
                       len: r_len[uwt_pkg::LEN_W-1:0]};
            k = k + 1'b1;
            n_open = 1'b0; n_len = '0; n_tail = '0; n_seen = 1'b0; n_fbh = 1'b0;
        end else begin
            n_esc = 1'b0;
            if (pre) begin
                res[k] = '{data: 8'h00, first: 1'b0, is_end: 1'b1, ascii: !r_fbh,
                           len: r_len[uwt_pkg::LEN_W-1:0]};
                k = k + 1'b1;
            end
            if (skip) begin
                n_open = 1'b0; n_len = '0; n_tail = '0; n_seen = 1'b0; n_fbh = 1'b0;
            end else begin
                res[k] = '{data: b, first: !o1, is_end: 1'b0, ascii: 1'b0, len: '0};
                k = k + 1'b1;
                if (post) begin
                    res[k] = '{data: 8'h00, first: 1'b0, is_end: 1'b1, ascii: !fbh_after,
                               len: len_after[uwt_pkg::LEN_W-1:0]};
                    k = k + 1'b1;
                    n_open = 1'b0; n_len = '0; n_tail = '0; n_seen = 1'b0; n_fbh = 1'b0;
                end else begin
                    n_open = 1'b1;
                    n_len  = len_after;
                    n_tail = (o1 && t1 != '0) ? t1 - 1'b1 :
                             (b[7] ? uwt_pkg::lead_tail(b) : '0);
                    n_seen = (o1 && !pre && r_seen) || aln;
                    n_fbh  = fbh_after;
                end
            end
        end
    end

    assign o_push        = accept && (k != '0);
    assign o_entry.count = k;
    assign o_entry.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_open <= 1'b0;
            r_len  <= '0;
            r_tail <= '0;
            r_seen <= 1'b0;
            r_fbh  <= 1'b0;
        end else if (accept) begin
            r_esc  <= n_esc;
            r_open <= n_open;
            r_len  <= n_len;
            r_tail <= n_tail;
            r_seen <= n_seen;
            r_fbh  <= n_fbh;
        end
    end

endmodule

// ----- design/uwt_queue.sv -----
module uwt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  uwt_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output uwt_pkg::t_entry   o_head,
    output uwt_pkg::t_qstat   o_stat
);

    uwt_pkg::t_entry               r_mem [uwt_pkg::QDEPTH];
    logic [uwt_pkg::QPTR_W-1:0]    r_wp, r_rp;
    logic [uwt_pkg::QPTR_W:0]      r_cnt;
    logic                          do_push, do_pop;

    assign o_stat.full  = (r_cnt == (uwt_pkg::QPTR_W+1)'(uwt_pkg::QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- design/uwt_back.sv -----
module uwt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  uwt_pkg::t_entry   i_head,
    input  uwt_pkg::t_qstat   i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output uwt_pkg::t_result  o_result
);

    logic                         r_valid;
    uwt_pkg::t_result             r_result;
    logic [uwt_pkg::SLOT_W-1:0]   r_sub;
    logic                         load, last;

    assign load     = !i_qstat.empty && (!r_valid || i_ready);
    assign last     = (r_sub == i_head.count - 1'b1);
    assign o_pop    = load && last;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_head.res[r_sub];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= last ? '0 : r_sub + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/utf8_word_tokenizer_unit.sv -----
// Byte-stream tokenizer.
// Input channel (i_valid / o_ready / i_text_byte) takes one raw text byte per
// item; byte 0 ends the input and always yields an end marker. Output channel
// (o_valid / i_ready) delivers one result per item: a token byte with
// o_is_first on the first byte of each token, or an end marker carrying the
// token length and its ASCII flag.
// One text byte causes zero to three results. The front classifies a byte in
// the cycle it is accepted and pushes its results as one entry into a
// four-entry queue; the back drains an entry one result per cycle, while
// i_ready is high, through an output register. Throughput with i_ready high:
// one byte per cycle while each byte yields at most one result; a byte that
// yields several results is sent one result at a time, the queue absorbing
// short bursts. The output port (one result per cycle) sets the sustained rate.
// Reset (i_rst_n low, synchronous) clears the tokenizer state, the queue and
// the output valid, and sets skip_line_breaks to 0. When the receiver stalls
// the output holds; the front keeps accepting until the queue fills.
// APB register at byte address 0: bit 0 = skip_line_breaks (skip CR and LF
// before a token like space and tab).
module utf8_word_tokenizer_unit #(
    parameter int MAX_TOKEN_LEN = 10240
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_text_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_data_byte,
    output logic                          o_is_first,
    output logic                          o_is_end_marker,
    output logic                          o_token_ascii,
    output logic [uwt_pkg::LEN_W-1:0]     o_token_length,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [uwt_pkg::ADDR_W-1:0]    paddr,
    input  logic [uwt_pkg::DATA_W-1:0]    pwdata,
    output logic [uwt_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic              r_skip_lb;
    logic              cfg_wr;
    logic              push, pop;
    uwt_pkg::t_entry   entry, head;
    uwt_pkg::t_qstat   qstat;
    uwt_pkg::t_result  result;

    // Config port: zero wait states, write lands on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_lb <= 1'b0;
        end else if (cfg_wr && (paddr[2] == uwt_pkg::REG_SKIP_LB)) begin
            r_skip_lb <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == uwt_pkg::REG_SKIP_LB) ?
                    {{(uwt_pkg::DATA_W-1){1'b0}}, r_skip_lb} : '0;

    // Front: classify the byte, update token state, build the result entry.
    uwt_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_text_byte (i_text_byte),
        .i_skip_lb   (r_skip_lb),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_entry     (entry)
    );

    // Queue: decouple classification from result delivery.
    uwt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // Back: advance through the head entry one result per cycle while i_ready is high.
    uwt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_data_byte     = result.data;
    assign o_is_first      = result.first;
    assign o_is_end_marker = result.is_end;
    assign o_token_ascii   = result.ascii;
    assign o_token_length  = result.len;

    // Front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    // Back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    // End markers carry no byte and no first flag; bytes carry no length and no ASCII flag.
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_end_marker ? (!o_is_first && o_data_byte == 8'h00)
                                     : (o_token_length == '0 && !o_token_ascii)))
        else $error("malformed result");

    // Output is empty the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid after reset");

endmodule
